// ----- hw/rtl/srmt_pkg.sv -----
`timescale 1ns / 1ps
package srmt_pkg;

  localparam int NUM_W      = 96;
  localparam int DEN_W      = 64;
  localparam int RATIO_BITS = 30;
  localparam int ACC_W      = 48;
  localparam int ITER_W     = 7;

  localparam logic [ITER_W-1:0] DIV_LONG  = ITER_W'(NUM_W);
  localparam logic [ITER_W-1:0] DIV_SHORT = ITER_W'(RATIO_BITS);
  localparam logic [30:0]       RATIO_ONE = 31'h4000_0000;
  localparam logic [3:0]        CURVE_LAST = 4'd9;

  localparam logic [31:0] VLIM_RESET = 32'd32768000;
  localparam logic [31:0] ALIM_RESET = 32'd655360000;
  localparam logic [31:0] TMIN_RESET = 32'd2621440;
  localparam logic [23:0] TPS_RESET  = 24'd1000000;

  localparam logic [2:0] CFG_VLIM = 3'd0;
  localparam logic [2:0] CFG_ALIM = 3'd1;
  localparam logic [2:0] CFG_TMIN = 3'd2;
  localparam logic [2:0] CFG_TPS  = 3'd3;

  typedef enum logic [4:0] {
    OP_NOP, OP_LATCH, OP_CLAMP, OP_MUL_VT, OP_DIV_T0, OP_T0, OP_MUL_RAMP, OP_DIV_RAMP,
    OP_RAMP, OP_MUL_N, OP_DIV_N, OP_N, OP_TICK, OP_DIV_RATIO, OP_RATIO, OP_RATIO_ONE,
    OP_CRV_INIT, OP_CRV_MUL, OP_CRV_ACC, OP_CRV_SHF, OP_SCL_HI, OP_SCL_LO, OP_SCL_SUM,
    OP_DIV_SECS, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic zero_case;
    logic ramp_on;
    logic div_idle;
    logic tc_full;
    logic br_a;
    logic br_b;
    logic last;
    logic kk_last;
    logic out_free;
  } dp_sts_t;

  function automatic logic signed [10:0] curve_coef(input logic [2:0] order,
                                                    input logic [3:0] kk);
    logic [2:0] row;
    logic signed [10:0] c;
    row = (order <= 3'd4) ? order : 3'd1;
    c = '0;
    case (row)
      3'd0: if (kk == 4'd1) c = 11'sd1;
      3'd1: begin
        if (kk == 4'd2) c = 11'sd3;
        if (kk == 4'd3) c = -11'sd2;
      end
      3'd2: begin
        if (kk == 4'd3) c = 11'sd10;
        if (kk == 4'd4) c = -11'sd15;
        if (kk == 4'd5) c = 11'sd6;
      end
      3'd3: begin
        if (kk == 4'd4) c = 11'sd35;
        if (kk == 4'd5) c = -11'sd84;
        if (kk == 4'd6) c = 11'sd70;
        if (kk == 4'd7) c = -11'sd20;
      end
      default: begin
        if (kk == 4'd5) c = 11'sd126;
        if (kk == 4'd6) c = -11'sd420;
        if (kk == 4'd7) c = 11'sd540;
        if (kk == 4'd8) c = -11'sd315;
        if (kk == 4'd9) c = 11'sd70;
      end
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/srmt_div.sv -----
`timescale 1ns / 1ps
module srmt_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [srmt_pkg::ITER_W-1:0]   iters,
  input  logic [srmt_pkg::NUM_W-1:0]    num0,
  input  logic [srmt_pkg::DEN_W-1:0]    rem0,
  input  logic [srmt_pkg::DEN_W-1:0]    den,
  output logic                          idle,
  output logic [srmt_pkg::NUM_W-1:0]    quot,
  output logic [srmt_pkg::DEN_W-1:0]    rem
);

  logic                        busy_r;
  logic [srmt_pkg::ITER_W-1:0] cnt_r;
  logic [srmt_pkg::NUM_W-1:0]  num_r;
  logic [srmt_pkg::DEN_W-1:0]  rem_r;
  logic [srmt_pkg::DEN_W-1:0]  den_r;
  logic [srmt_pkg::DEN_W:0]    sh;
  logic [srmt_pkg::DEN_W:0]    diff;
  logic                        ge;

  assign sh   = {rem_r, num_r[srmt_pkg::NUM_W-1]};
  assign diff = sh - {1'b0, den_r};
  assign ge   = (sh >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= iters;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == srmt_pkg::ITER_W'(1)) busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num0;
      rem_r <= rem0;
      den_r <= den;
    end else if (busy_r) begin
      num_r <= {num_r[srmt_pkg::NUM_W-2:0], ge};
      rem_r <= ge ? diff[srmt_pkg::DEN_W-1:0] : sh[srmt_pkg::DEN_W-1:0];
    end
  end

  assign idle = !busy_r;
  assign quot = num_r;
  assign rem  = rem_r;

endmodule

// ----- hw/rtl/srmt_dp.sv -----
`timescale 1ns / 1ps
module srmt_dp #(
  parameter int MAX_TICKS = 65536,
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  srmt_pkg::dp_cmd_t       cmd,
  output srmt_pkg::dp_sts_t       sts,
  input  logic [127:0]            in_tdata,
  input  logic [2:0]              in_tuser,
  input  logic                    cfg_valid,
  input  logic [2:0]              cfg_index,
  input  logic [31:0]             cfg_data,
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [31:0]             out_tdata,
  output logic                    out_tuser
);

  localparam int CNT_W = $clog2(MAX_TICKS + 1) + 1;
  localparam int NW = srmt_pkg::NUM_W;
  localparam int AW = srmt_pkg::ACC_W;

  logic [31:0] vlim_r, alim_r, tmin_r;
  logic [23:0] tps_r;
  logic [31:0] vlim_e, alim_e, tmin_e;
  logic [23:0] tps_e;

  logic [31:0] dist_r, vcmd_r, acmd_r, vin_r;
  logic [2:0]  order_r;
  logic [31:0] v_r, a_r, ve_r, tmin_e_r;
  logic [23:0] tps_e_r;
  logic [63:0] vt_r, t0_r, finc_r, cur_r, total_r, scl_r, prod_r;
  logic [62:0] ramp_r, tc_r;
  logic [CNT_W-1:0] n_r, half_r, k_r, acnt_r;
  logic        clipped_r, mode_a_r;
  logic [30:0] p_r, x_r, s_r;
  logic signed [AW-1:0] acc_r;
  logic [3:0]  kk_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_user_r;

  logic [31:0] vv, aa, vee;
  logic [31:0] mul_a, mul_b;
  logic signed [10:0] coef;
  logic [9:0]  coef_mag;
  logic [30:0] s_w;
  logic        active, br_a, br_b;
  logic [64:0] tot_sum, tc_sum;
  logic [63:0] per, scaled;
  logic [CNT_W:0] reach;

  logic                        div_start, div_idle;
  logic [srmt_pkg::ITER_W-1:0] div_iters;
  logic [NW-1:0]               div_num0, quot;
  logic [63:0]                 div_rem0, div_den, drem;
  logic [CNT_W-1:0]            nq, nr;
  logic                        rnd;

  assign vlim_e = (vlim_r == '0) ? srmt_pkg::VLIM_RESET : vlim_r;
  assign alim_e = (alim_r == '0) ? srmt_pkg::ALIM_RESET : alim_r;
  assign tmin_e = (tmin_r == '0) ? srmt_pkg::TMIN_RESET : tmin_r;
  assign tps_e  = (tps_r == '0) ? srmt_pkg::TPS_RESET : tps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vlim_r <= srmt_pkg::VLIM_RESET;
      alim_r <= srmt_pkg::ALIM_RESET;
      tmin_r <= srmt_pkg::TMIN_RESET;
      tps_r  <= srmt_pkg::TPS_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        srmt_pkg::CFG_VLIM: vlim_r <= cfg_data;
        srmt_pkg::CFG_ALIM: alim_r <= cfg_data;
        srmt_pkg::CFG_TMIN: tmin_r <= cfg_data;
        srmt_pkg::CFG_TPS:  tps_r  <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  assign vv  = (vcmd_r < vlim_e) ? vcmd_r : vlim_e;
  assign aa  = (acmd_r < alim_e) ? ((acmd_r == '0) ? 32'd1 : acmd_r)
                                 : alim_e;
  assign vee = (vin_r < vv) ? ((vin_r == '0) ? 32'd1 : vin_r)
                            : ((vv == '0) ? 32'd1 : vv);

  assign coef     = srmt_pkg::curve_coef(order_r, kk_r);
  assign coef_mag = coef[10] ? 10'(-coef) : coef[9:0];

  assign s_w = (acc_r <= 0) ? 31'd0 :
               (acc_r > AW'(srmt_pkg::RATIO_ONE)) ? srmt_pkg::RATIO_ONE : acc_r[30:0];

  assign active = (ramp_r != '0) && (finc_r != '0);
  assign reach  = {1'b0, k_r} + {1'b0, acnt_r} + (CNT_W + 1)'(2);
  assign br_a   = active && (k_r <= half_r) && (cur_r > {32'b0, tmin_e_r});
  assign br_b   = active && !br_a && (acnt_r != '0) && (reach >= {1'b0, n_r}) &&
                  (cur_r < t0_r);

  assign tot_sum = {1'b0, total_r} + {1'b0, cur_r};
  assign tc_sum  = {2'b0, tc_r} + {1'b0, cur_r};
  assign scaled  = scl_r + (prod_r >> srmt_pkg::RATIO_BITS);
  assign per     = t0_r - scaled;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      srmt_pkg::OP_MUL_VT:   begin mul_a = v_r;            mul_b = tmin_e_r;       end
      srmt_pkg::OP_MUL_RAMP: begin mul_a = v_r - ve_r;     mul_b = {8'b0, tps_e_r}; end
      srmt_pkg::OP_MUL_N:    begin mul_a = dist_r;         mul_b = {8'b0, tps_e_r}; end
      srmt_pkg::OP_CRV_MUL:  begin mul_a = 32'(coef_mag);  mul_b = 32'(p_r);      end
      srmt_pkg::OP_CRV_ACC:  begin mul_a = 32'(p_r);       mul_b = 32'(x_r);      end
      srmt_pkg::OP_SCL_HI:   begin mul_a = finc_r[63:32];  mul_b = 32'(s_w);      end
      srmt_pkg::OP_SCL_LO:   begin mul_a = finc_r[31:0];   mul_b = 32'(s_r);      end
      default: ;
    endcase
  end

  always_comb begin
    div_start = 1'b1;
    div_iters = srmt_pkg::DIV_LONG;
    div_num0  = NW'(prod_r);
    div_rem0  = '0;
    div_den   = 64'(ve_r);
    case (cmd.op)
      srmt_pkg::OP_DIV_T0:   ;
      srmt_pkg::OP_DIV_RAMP: begin
        div_num0 = NW'(prod_r) << FRAC_BITS;
        div_den  = 64'(a_r);
      end
      srmt_pkg::OP_DIV_N: begin
        div_num0 = NW'(prod_r) << FRAC_BITS;
        div_den  = vt_r;
      end
      srmt_pkg::OP_DIV_RATIO: begin
        div_iters = srmt_pkg::DIV_SHORT;
        div_num0  = '0;
        div_rem0  = 64'(tc_r);
        div_den   = 64'(ramp_r);
      end
      srmt_pkg::OP_DIV_SECS: begin
        div_num0 = NW'(total_r);
        div_den  = 64'(tps_e_r);
      end
      default: div_start = 1'b0;
    endcase
  end

  srmt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .iters (div_iters),
    .num0  (div_num0),
    .rem0  (div_rem0),
    .den   (div_den),
    .idle  (div_idle),
    .quot  (quot),
    .rem   (drem)
  );

  assign rnd = ({drem, 1'b0} >= {1'b0, vt_r});
  assign nq  = (quot > NW'(MAX_TICKS + 1)) ? CNT_W'(MAX_TICKS + 1) :
               ((rnd && quot < NW'(MAX_TICKS + 1)) ? quot[CNT_W-1:0] + 1'b1
                                                   : quot[CNT_W-1:0]);
  assign nr  = (nq == '0) ? CNT_W'(1) :
               (nq > CNT_W'(MAX_TICKS)) ? CNT_W'(MAX_TICKS) : nq;

  always_ff @(posedge clk) begin
    if (cmd.op == srmt_pkg::OP_MUL_VT || cmd.op == srmt_pkg::OP_MUL_RAMP ||
        cmd.op == srmt_pkg::OP_MUL_N || cmd.op == srmt_pkg::OP_CRV_MUL ||
        cmd.op == srmt_pkg::OP_CRV_ACC || cmd.op == srmt_pkg::OP_SCL_HI ||
        cmd.op == srmt_pkg::OP_SCL_LO) begin
      prod_r <= 64'(mul_a) * 64'(mul_b);
    end
    unique case (cmd.op)
      srmt_pkg::OP_LATCH: begin
        dist_r  <= in_tdata[31:0];
        vcmd_r  <= in_tdata[63:32];
        acmd_r  <= in_tdata[95:64];
        vin_r   <= in_tdata[127:96];
        order_r <= in_tuser;
      end
      srmt_pkg::OP_CLAMP: begin
        v_r       <= vv;
        a_r       <= aa;
        ve_r      <= vee;
        tmin_e_r  <= tmin_e;
        tps_e_r   <= tps_e;
        total_r   <= '0;
        clipped_r <= 1'b0;
        ramp_r    <= '0;
        finc_r    <= '0;
      end
      srmt_pkg::OP_DIV_T0: vt_r <= prod_r;
      srmt_pkg::OP_T0: t0_r <= (quot[63:0] < {32'b0, tmin_e_r}) ? {32'b0, tmin_e_r}
                                                                : quot[63:0];
      srmt_pkg::OP_RAMP: begin
        ramp_r <= (quot > NW'(64'h4000_0000_0000_0000)) ? 63'h4000_0000_0000_0000
                                                        : quot[62:0];
        finc_r <= t0_r - {32'b0, tmin_e_r};
      end
      srmt_pkg::OP_N: begin
        n_r       <= nr;
        half_r    <= nr >> 1;
        clipped_r <= (nq > CNT_W'(MAX_TICKS));
        cur_r     <= t0_r;
        k_r       <= CNT_W'(1);
        tc_r      <= '0;
        acnt_r    <= '0;
      end
      srmt_pkg::OP_TICK: begin
        total_r <= tot_sum[64] ? '1 : tot_sum[63:0];
        if (br_a) begin
          tc_r     <= (tc_sum > {2'b0, ramp_r}) ? ramp_r : tc_sum[62:0];
          acnt_r   <= k_r;
          mode_a_r <= 1'b1;
        end else if (br_b) begin
          tc_r     <= ({1'b0, tc_r} > cur_r) ? 63'({1'b0, tc_r} - cur_r) : '0;
          mode_a_r <= 1'b0;
        end else begin
          k_r <= k_r + 1'b1;
        end
      end
      srmt_pkg::OP_RATIO:     x_r <= 31'(quot[srmt_pkg::RATIO_BITS-1:0]);
      srmt_pkg::OP_RATIO_ONE: x_r <= srmt_pkg::RATIO_ONE;
      srmt_pkg::OP_CRV_INIT: begin
        p_r   <= srmt_pkg::RATIO_ONE;
        kk_r  <= '0;
        acc_r <= '0;
      end
      srmt_pkg::OP_CRV_ACC:
        acc_r <= coef[10] ? acc_r - $signed({1'b0, prod_r[AW-2:0]})
                          : acc_r + $signed({1'b0, prod_r[AW-2:0]});
      srmt_pkg::OP_CRV_SHF: begin
        p_r  <= 31'(prod_r >> srmt_pkg::RATIO_BITS);
        kk_r <= kk_r + 1'b1;
      end
      srmt_pkg::OP_SCL_HI: s_r <= s_w;
      srmt_pkg::OP_SCL_LO: scl_r <= prod_r << 2;
      srmt_pkg::OP_SCL_SUM: begin
        if (mode_a_r) cur_r <= (per < {32'b0, tmin_e_r}) ? {32'b0, tmin_e_r} : per;
        else          cur_r <= (per > t0_r) ? t0_r : per;
        k_r <= k_r + 1'b1;
      end
      srmt_pkg::OP_OUT: begin
        out_data_r <= (quot > NW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : quot[31:0];
        out_user_r <= clipped_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == srmt_pkg::OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign sts.zero_case = (dist_r == '0) || (vv == '0);
  assign sts.ramp_on   = (t0_r > {32'b0, tmin_e_r}) && (v_r > ve_r);
  assign sts.div_idle  = div_idle;
  assign sts.tc_full   = (tc_r == ramp_r);
  assign sts.br_a      = br_a;
  assign sts.br_b      = br_b;
  assign sts.last      = (k_r == n_r);
  assign sts.kk_last   = (kk_r == srmt_pkg::CURVE_LAST);
  assign sts.out_free  = !out_valid_r || out_tready;

  a_cur_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == srmt_pkg::OP_TICK) |-> (cur_r >= {32'b0, tmin_e_r} && cur_r <= t0_r))
    else $error("period outside [tmin, t0]");

  a_tick_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == srmt_pkg::OP_TICK) |-> (tc_r <= ramp_r && acnt_r <= k_r && k_r <= n_r))
    else $error("ramp timer or tick counters out of range");

  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == srmt_pkg::OP_N) |=> (n_r != '0 && n_r <= CNT_W'(MAX_TICKS)))
    else $error("interrupt count out of range");

  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> div_idle)
    else $error("divider started while busy");

endmodule

// ----- hw/rtl/srmt_ctrl.sv -----
`timescale 1ns / 1ps
module srmt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  srmt_pkg::dp_sts_t  sts,
  output srmt_pkg::dp_cmd_t  cmd
);

  typedef enum logic [23:0] {
    S_IDLE  = 24'h000001,
    S_CLAMP = 24'h000002,
    S_MVT   = 24'h000004,
    S_DT0   = 24'h000008,
    S_WT0   = 24'h000010,
    S_MR    = 24'h000020,
    S_DR    = 24'h000040,
    S_WR    = 24'h000080,
    S_MN    = 24'h000100,
    S_DN    = 24'h000200,
    S_WN    = 24'h000400,
    S_TICK  = 24'h000800,
    S_DRAT  = 24'h001000,
    S_WRAT  = 24'h002000,
    S_CINI  = 24'h004000,
    S_CMUL  = 24'h008000,
    S_CACC  = 24'h010000,
    S_CSHF  = 24'h020000,
    S_SHI   = 24'h040000,
    S_SLO   = 24'h080000,
    S_SSUM  = 24'h100000,
    S_SECS  = 24'h200000,
    S_WSEC  = 24'h400000,
    S_OUT   = 24'h800000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = srmt_pkg::OP_NOP;
    unique case (state_r)
      S_IDLE: if (in_tvalid) begin
        cmd.op    = srmt_pkg::OP_LATCH;
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.op    = srmt_pkg::OP_CLAMP;
        state_nxt = sts.zero_case ? S_SECS : S_MVT;
      end
      S_MVT: begin
        cmd.op    = srmt_pkg::OP_MUL_VT;
        state_nxt = S_DT0;
      end
      S_DT0: begin
        cmd.op    = srmt_pkg::OP_DIV_T0;
        state_nxt = S_WT0;
      end
      S_WT0: if (sts.div_idle) begin
        cmd.op    = srmt_pkg::OP_T0;
        state_nxt = S_MR;
      end
      S_MR: begin
        if (sts.ramp_on) begin
          cmd.op    = srmt_pkg::OP_MUL_RAMP;
          state_nxt = S_DR;
        end else begin
          state_nxt = S_MN;
        end
      end
      S_DR: begin
        cmd.op    = srmt_pkg::OP_DIV_RAMP;
        state_nxt = S_WR;
      end
      S_WR: if (sts.div_idle) begin
        cmd.op    = srmt_pkg::OP_RAMP;
        state_nxt = S_MN;
      end
      S_MN: begin
        cmd.op    = srmt_pkg::OP_MUL_N;
        state_nxt = S_DN;
      end
      S_DN: begin
        cmd.op    = srmt_pkg::OP_DIV_N;
        state_nxt = S_WN;
      end
      S_WN: if (sts.div_idle) begin
        cmd.op    = srmt_pkg::OP_N;
        state_nxt = S_TICK;
      end
      S_TICK: begin
        cmd.op = srmt_pkg::OP_TICK;
        if (sts.br_a || sts.br_b) state_nxt = S_DRAT;
        else if (sts.last)        state_nxt = S_SECS;
      end
      S_DRAT: begin
        if (sts.tc_full) begin
          cmd.op    = srmt_pkg::OP_RATIO_ONE;
          state_nxt = S_CINI;
        end else begin
          cmd.op    = srmt_pkg::OP_DIV_RATIO;
          state_nxt = S_WRAT;
        end
      end
      S_WRAT: if (sts.div_idle) begin
        cmd.op    = srmt_pkg::OP_RATIO;
        state_nxt = S_CINI;
      end
      S_CINI: begin
        cmd.op    = srmt_pkg::OP_CRV_INIT;
        state_nxt = S_CMUL;
      end
      S_CMUL: begin
        cmd.op    = srmt_pkg::OP_CRV_MUL;
        state_nxt = S_CACC;
      end
      S_CACC: begin
        cmd.op    = srmt_pkg::OP_CRV_ACC;
        state_nxt = sts.kk_last ? S_SHI : S_CSHF;
      end
      S_CSHF: begin
        cmd.op    = srmt_pkg::OP_CRV_SHF;
        state_nxt = S_CMUL;
      end
      S_SHI: begin
        cmd.op    = srmt_pkg::OP_SCL_HI;
        state_nxt = S_SLO;
      end
      S_SLO: begin
        cmd.op    = srmt_pkg::OP_SCL_LO;
        state_nxt = S_SSUM;
      end
      S_SSUM: begin
        cmd.op    = srmt_pkg::OP_SCL_SUM;
        state_nxt = sts.last ? S_SECS : S_TICK;
      end
      S_SECS: begin
        cmd.op    = srmt_pkg::OP_DIV_SECS;
        state_nxt = S_WSEC;
      end
      S_WSEC: if (sts.div_idle) state_nxt = S_OUT;
      S_OUT: if (sts.out_free) begin
        cmd.op    = srmt_pkg::OP_OUT;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign in_tready = (state_r == S_IDLE);

  a_wait_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> sts.div_idle)
    else $error("result taken before division finished");

  a_accept_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_CLAMP))
    else $error("accepted beat not processed");

  a_tick_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TICK && !sts.br_a && !sts.br_b && sts.last) |=> (state_r == S_SECS))
    else $error("tick loop missed its end");

endmodule

// ----- hw/rtl/smoothstep_ramp_move_time_unit.sv -----
`timescale 1ns / 1ps
// Move-time estimator for a smoothstep stepper ramp. One request beat in, one result
// beat out. An item runs the start-period division, the ramp-time division when there is
// a ramp, and the interrupt-count division, then one tick step per simulated interrupt N
// and the final seconds division. Every interrupt that lies on the ramp adds a 30-step
// ratio division (skipped once the ramp timer is full) and a ten-term curve on the
// shared 32x32 multiplier. The bit-serial divider and that single multiplier set the pace;
// one request is worked at a time. A zero distance or zero velocity goes straight to the final seconds division.
// A new request may be taken while the previous result still waits at the output.
module smoothstep_ramp_move_time_unit #(
  parameter int MAX_TICKS = 65536,
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // move_distance, target_velocity, ramp_acceleration,
                                   // entry_velocity (32 bits each)
  input  logic [2:0]   in_tuser,   // curve_order
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // move_seconds
  output logic         out_tuser,  // ticks_clipped
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  srmt_pkg::dp_cmd_t cmd;
  srmt_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  srmt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  srmt_dp #(
    .MAX_TICKS (MAX_TICKS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- tb/sv/smoothstep_ramp_move_time_unit_tb.sv -----
`timescale 1ns / 1ps
module smoothstep_ramp_move_time_unit_tb;

  localparam int          TICK_CAP  = 65536;
  localparam int          FRAC      = 16;
  localparam logic [2:0]  CFG_SPARE = 3'd7;
  localparam int          STALL_MAX = 1000000;
  localparam longint unsigned ONE_Q30 = 64'h4000_0000;
  localparam longint unsigned ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [31:0] travel;
    logic [31:0] vcmd;
    logic [31:0] acmd;
    logic [31:0] vin;
    logic [2:0]  order;
  } move_t;

  typedef struct {
    logic [31:0] secs;
    logic        clip;
  } move_time_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [127:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  logic [31:0] vlim_r = srmt_pkg::VLIM_RESET;
  logic [31:0] alim_r = srmt_pkg::ALIM_RESET;
  logic [31:0] tmin_r = srmt_pkg::TMIN_RESET;
  logic [23:0] tps_r  = srmt_pkg::TPS_RESET;

  move_t      pending_moves[$];
  move_time_t expected_times[$];
  int         idle_mode = 0;
  bit         hold_req = 1'b0;
  int         hold_left = 0;
  int         fail_cnt = 0;
  int         quiet_cycles = 0;

  always #6 clk = ~clk;

  smoothstep_ramp_move_time_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic longint unsigned div_sat(longint unsigned num, longint unsigned den,
                                              int sh, longint unsigned cap, bit rnd);
    longint unsigned q, r, b;
    q = num / den;
    r = num % den;
    if (q > cap) return cap;
    for (int i = 0; i < sh; i++) begin
      b = (r >= den - r) ? 1 : 0;
      r = b ? (r - (den - r)) : (r + r);
      if (q > (cap >> 1)) return cap;
      q = (q << 1) + b;
      if (q > cap) return cap;
    end
    if (rnd && r >= den - r && q < cap) q++;
    return q;
  endfunction

  function automatic int smooth_coef(logic [2:0] order, int k);
    int row;
    int c;
    row = (order <= 3'd4) ? order : 1;
    c = 0;
    case (row)
      0: if (k == 1) c = 1;
      1: begin
        if (k == 2) c = 3;
        if (k == 3) c = -2;
      end
      2: begin
        if (k == 3) c = 10;
        if (k == 4) c = -15;
        if (k == 5) c = 6;
      end
      3: begin
        if (k == 4) c = 35;
        if (k == 5) c = -84;
        if (k == 6) c = 70;
        if (k == 7) c = -20;
      end
      default: begin
        if (k == 5) c = 126;
        if (k == 6) c = -420;
        if (k == 7) c = 540;
        if (k == 8) c = -315;
        if (k == 9) c = 70;
      end
    endcase
    return c;
  endfunction

  function automatic longint unsigned smoothstep_q30(longint unsigned x, logic [2:0] order);
    longint unsigned p, pos, neg;
    int c;
    p = ONE_Q30;
    pos = 0;
    neg = 0;
    if (x > ONE_Q30) x = ONE_Q30;
    for (int k = 0; k < 10; k++) begin
      c = smooth_coef(order, k);
      if (k > 0) p = (p * x) >> 30;
      if (c > 0) pos += longint'(c) * p;
      else if (c < 0) neg += longint'(-c) * p;
    end
    if (pos <= neg) return 0;
    pos -= neg;
    return (pos > ONE_Q30) ? ONE_Q30 : pos;
  endfunction

  function automatic longint unsigned period_on_ramp(longint unsigned t0, longint unsigned span,
                                                     longint unsigned tc, longint unsigned ramp,
                                                     logic [2:0] order);
    longint unsigned s, hi, lo;
    s = smoothstep_q30(div_sat(tc, ramp, 30, ONE_Q30, 1'b0), order);
    hi = span >> 32;
    lo = span & 64'hFFFF_FFFF;
    return t0 - (((hi * s) << 2) + ((lo * s) >> 30));
  endfunction

  function automatic longint unsigned add_sat(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s < a) ? ALL_ONES : s;
  endfunction

  function automatic move_time_t predict_move_time(move_t m);
    move_time_t res;
    longint unsigned vl, al, tmin, tps, v, a, ve, t0, ramp, span, n, half, cur, tc, total;
    longint unsigned el, ramp_ticks, secs;
    bit active;
    res.secs = '0;
    res.clip = 1'b0;
    vl = vlim_r ? vlim_r : srmt_pkg::VLIM_RESET;
    al = alim_r ? alim_r : srmt_pkg::ALIM_RESET;
    tmin = tmin_r ? tmin_r : srmt_pkg::TMIN_RESET;
    tps = tps_r ? tps_r : srmt_pkg::TPS_RESET;
    if (m.travel == 0) return res;
    v = (m.vcmd < vl) ? m.vcmd : vl;
    if (v == 0) return res;
    a = (m.acmd < al) ? m.acmd : al;
    if (a == 0) a = 1;
    ve = (m.vin < v) ? m.vin : v;
    if (ve == 0) ve = 1;
    t0 = div_sat(v * tmin, ve, 0, ALL_ONES, 1'b0);
    if (t0 < tmin) t0 = tmin;
    ramp = 0;
    span = 0;
    if (t0 > tmin && v > ve) begin
      ramp = div_sat((v - ve) * tps, a, FRAC, 64'h4000_0000_0000_0000, 1'b0);
      span = t0 - tmin;
    end
    active = (ramp > 0 && span > 0);
    n = div_sat(longint'(m.travel) * tps, v * tmin, FRAC, TICK_CAP + 1, 1'b1);
    if (n == 0) n = 1;
    if (n > TICK_CAP) begin
      n = TICK_CAP;
      res.clip = 1'b1;
    end
    half = n / 2;
    cur = t0;
    tc = 0;
    total = 0;
    ramp_ticks = 0;
    for (longint unsigned k = 1; k <= n; k++) begin
      el = cur;
      total = add_sat(total, el);
      if (!active) continue;
      if (k <= half && cur > tmin) begin
        tc = add_sat(tc, el);
        if (tc > ramp) tc = ramp;
        cur = period_on_ramp(t0, span, tc, ramp, m.order);
        if (cur < tmin) cur = tmin;
        ramp_ticks = k;
      end else if (ramp_ticks > 0 && longint'(k) >= longint'(n) - longint'(ramp_ticks) - 2
                   && cur < t0) begin
        tc = (tc > el) ? tc - el : 0;
        cur = period_on_ramp(t0, span, tc, ramp, m.order);
        if (cur > t0) cur = t0;
      end
    end
    secs = total / tps;
    res.secs = (secs > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : secs[31:0];
    return res;
  endfunction

  // distance chosen so that the move takes about ticks interrupts
  function automatic move_t plan_move(int ticks, bit ramped);
    move_t m;
    logic [127:0] d;
    longint unsigned vl, v, tmin, tps;
    vl = vlim_r ? vlim_r : srmt_pkg::VLIM_RESET;
    tmin = tmin_r ? tmin_r : srmt_pkg::TMIN_RESET;
    tps = tps_r ? tps_r : srmt_pkg::TPS_RESET;
    m.vcmd = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, vl);
    v = (m.vcmd < vl) ? m.vcmd : vl;
    if (v == 0) v = 1;
    d = (128'(v) * 128'(tmin) * 128'(ticks)) / (128'(tps) << FRAC);
    m.travel = (d > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : d[31:0];
    if (m.travel == 0) m.travel = 1;
    case ($urandom_range(0, 2))
      0: m.acmd = $urandom;
      1: m.acmd = $urandom_range(1, 65536 * 2000);
      default: m.acmd = $urandom >> $urandom_range(0, 31);
    endcase
    if (ramped) m.vin = 32'(v >> $urandom_range(1, 10));
    else m.vin = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'(v + $urandom_range(0, 100));
    m.order = 3'($urandom_range(0, 7));
    return m;
  endfunction

  always @(posedge clk) begin
    move_t m;
    int idle_pct;
    idle_pct = (idle_mode == 0) ? 36 : (idle_mode == 1) ? 59 : 0;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_moves.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        m = pending_moves.pop_front();
        in_tdata <= {m.vin, m.acmd, m.vcmd, m.travel};
        in_tuser <= m.order;
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    move_t m;
    if (rst_n && in_tvalid && in_tready) begin
      m.travel = in_tdata[31:0];
      m.vcmd = in_tdata[63:32];
      m.acmd = in_tdata[95:64];
      m.vin = in_tdata[127:96];
      m.order = in_tuser;
      expected_times.push_back(predict_move_time(m));
    end
  end

  always @(posedge clk) begin
    int idle_pct;
    idle_pct = (idle_mode == 0) ? 59 : (idle_mode == 1) ? 36 : 0;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_req && hold_left == 0) begin
      hold_left <= 3000;
      out_tready <= 1'b0;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      if (hold_left == 1) hold_left <= -1;
      out_tready <= ($urandom_range(0, 99) >= idle_pct);
    end
  end

  always @(posedge clk) begin
    move_time_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_times.size() == 0) begin
        $error("unexpected result beat: move_seconds=%0h ticks_clipped=%0b",
               out_tdata, out_tuser);
        fail_cnt++;
      end else begin
        e = expected_times.pop_front();
        if (out_tdata !== e.secs) begin
          $error("move_seconds: expected %0h, got %0h", e.secs, out_tdata);
          fail_cnt++;
        end
        if (out_tuser !== e.clip) begin
          $error("ticks_clipped: expected %0b, got %0b", e.clip, out_tuser);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      srmt_pkg::CFG_VLIM: vlim_r = val;
      srmt_pkg::CFG_ALIM: alim_r = val;
      srmt_pkg::CFG_TMIN: tmin_r = val;
      srmt_pkg::CFG_TPS:  tps_r = val[23:0];
      default: ;
    endcase
  endtask

  task automatic drain;
    while (pending_moves.size() > 0 || in_tvalid || expected_times.size() > 0)
      @(negedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic add_move(logic [31:0] d, logic [31:0] vc, logic [31:0] ac,
                          logic [31:0] vi, logic [2:0] o);
    move_t m;
    m.travel = d;
    m.vcmd = vc;
    m.acmd = ac;
    m.vin = vi;
    m.order = o;
    pending_moves.push_back(m);
  endtask

  task automatic random_moves(int cnt);
    move_t m;
    for (int i = 0; i < cnt; i++) begin
      case ($urandom_range(0, 9))
        0: m = plan_move($urandom_range(1, 400), 1'b0);
        1: begin
          m = plan_move(1, 1'b1);
          m.travel = $urandom_range(0, 3);
        end
        default: m = plan_move($urandom_range(2, 120), 1'b1);
      endcase
      pending_moves.push_back(m);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_move(32'd0, 32'd32768000, 32'd65536000, 32'd655360, 3'd1);
    add_move(32'd65536, 32'd0, 32'd65536000, 32'd655360, 3'd1);
    add_move(32'd1, 32'd32768000, 32'd65536000, 32'd655360, 3'd2);
    add_move(32'd65536, 32'd32768000, 32'd0, 32'd0, 3'd3);
    add_move(32'd65536, 32'd32768000, 32'hFFFF_FFFF, 32'd65536, 3'd4);
    for (int o = 0; o < 8; o++)
      add_move(32'd131072, 32'd16384000, 32'd6553600, 32'd327680, 3'(o));
    add_move(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
    add_move(32'hFFFF_FFFF, 32'd65536, 32'd65536, 32'd65536, 3'd0);
    add_move(32'd262144, 32'hFFFF_FFFF, 32'd1, 32'd1, 3'd4);
    add_move(32'd65536, 32'd655360, 32'd655360, 32'd1310720, 3'd1);
    drain();

    hold_req = 1'b1;
    random_moves(10);
    drain();
    hold_req = 1'b0;

    write_reg(srmt_pkg::CFG_VLIM, 32'd0);
    write_reg(srmt_pkg::CFG_ALIM, 32'd0);
    write_reg(srmt_pkg::CFG_TMIN, 32'd0);
    write_reg(srmt_pkg::CFG_TPS, 32'd0);
    write_reg(CFG_SPARE, 32'hDEAD_BEEF);
    random_moves(15);
    drain();

    idle_mode = 1;
    write_reg(srmt_pkg::CFG_VLIM, 32'hFFFF_FFFF);
    write_reg(srmt_pkg::CFG_ALIM, 32'hFFFF_FFFF);
    write_reg(srmt_pkg::CFG_TMIN, 32'd1);
    write_reg(srmt_pkg::CFG_TPS, 32'h00FF_FFFF);
    random_moves(15);
    drain();

    write_reg(srmt_pkg::CFG_VLIM, 32'd1);
    write_reg(srmt_pkg::CFG_ALIM, 32'd1);
    write_reg(srmt_pkg::CFG_TMIN, 32'hFFFF_FFFF);
    write_reg(srmt_pkg::CFG_TPS, 32'd1);
    random_moves(10);
    drain();

    idle_mode = 2;
    write_reg(srmt_pkg::CFG_VLIM, $urandom_range(65536, 32'h7FFF_FFFF));
    write_reg(srmt_pkg::CFG_ALIM, $urandom);
    write_reg(srmt_pkg::CFG_TMIN, $urandom_range(65536, 32'd6553600));
    write_reg(srmt_pkg::CFG_TPS, $urandom_range(1000, 32'h00FF_FFFF));
    random_moves(15);
    drain();

    write_reg(srmt_pkg::CFG_VLIM, srmt_pkg::VLIM_RESET);
    write_reg(srmt_pkg::CFG_ALIM, srmt_pkg::ALIM_RESET);
    write_reg(srmt_pkg::CFG_TMIN, srmt_pkg::TMIN_RESET);
    write_reg(srmt_pkg::CFG_TPS, 32'(srmt_pkg::TPS_RESET));
    random_moves(20);
    drain();

    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
